### sv/dte_pkg.sv
package dte_pkg;

  // Defaults for the top level parameters
  localparam int LENGTH_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Most bytes one start item can produce: tag, 0x82, two length bytes, pad, first byte
  localparam int JOB_BYTES = 6;
  localparam int JOB_CNT_W = $clog2(JOB_BYTES + 1);

  // Commands
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  // Element types
  localparam logic [2:0] TYPE_INTEGER   = 3'd0;
  localparam logic [2:0] TYPE_BITSTRING = 3'd1;
  localparam logic [2:0] TYPE_OCTETSTR  = 3'd2;
  localparam logic [2:0] TYPE_OID       = 3'd3;
  localparam logic [2:0] TYPE_NULL      = 3'd4;
  localparam logic [2:0] TYPE_SEQUENCE  = 3'd5;
  localparam logic [2:0] TYPE_UTF8STR   = 3'd6;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TOO_LONG = 2'd1;
  localparam logic [1:0] ST_NO_ELEM  = 2'd2;

  // Byte constants
  localparam logic [7:0] LEN_LONG1 = 8'h81;
  localparam logic [7:0] LEN_LONG2 = 8'h82;
  localparam logic [7:0] TOP_BIT   = 8'h80;
  localparam logic [7:0] ZERO_BYTE = 8'h00;
  localparam int         SHORT_MAX = 128;

  typedef struct packed {
    logic        command;
    logic [2:0]  elem_type;
    logic [15:0] content_length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic [1:0] status;
  } out_item_t;

  // One queued job: up to six bytes, sent from bytes[0] upward
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [JOB_CNT_W-1:0]      cnt;
    logic                      last;    // last flag on the final byte of the job
    logic [1:0]                status;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] tag_of(input logic [2:0] t);
    logic [7:0] tag;
    case (t)
      TYPE_INTEGER:   tag = 8'h02;
      TYPE_BITSTRING: tag = 8'h03;
      TYPE_OCTETSTR:  tag = 8'h04;
      TYPE_OID:       tag = 8'h06;
      TYPE_NULL:      tag = 8'h05;
      TYPE_SEQUENCE:  tag = 8'h30;
      TYPE_UTF8STR:   tag = 8'h0C;
      default:        tag = 8'h04;
    endcase
    return tag;
  endfunction

endpackage

### sv/dte_front.sv
module dte_front import dte_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_beat,
  input  q_stat_t  q_stat,
  output logic     push,
  output job_t     job
);

  localparam logic [16:0] LEN_CAP = (LENGTH_BITS >= 16) ? 17'h0FFFF :
                                    17'((64'd1 << LENGTH_BITS) - 64'd1);

  logic [15:0] bytes_left, bytes_left_next;
  logic        element_open, element_open_next;

  logic                     extra;
  logic [16:0]              eff;
  logic [15:0]              clen;
  logic [JOB_CNT_W-1:0]     n;
  logic [JOB_BYTES-1:0][7:0] b;
  logic [15:0]              left_dec;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;
  assign left_dec = bytes_left - 16'd1;

  always_comb begin
    bytes_left_next   = bytes_left;
    element_open_next = element_open;
    b                 = '0;
    n                 = '0;
    extra             = 1'b0;
    clen              = in_beat.content_length;
    eff               = '0;
    job               = '0;

    if (in_beat.command == CMD_DATA) begin
      if (!element_open) begin
        job.bytes  = '0;
        job.cnt    = JOB_CNT_W'(1);
        job.last   = 1'b0;
        job.status = ST_NO_ELEM;
      end else begin
        bytes_left_next   = left_dec;
        element_open_next = (left_dec != 16'd0);
        b[0]              = in_beat.data_byte;
        job.bytes         = b;
        job.cnt           = JOB_CNT_W'(1);
        job.last          = (left_dec == 16'd0);
        job.status        = ST_OK;
      end
    end else begin
      bytes_left_next   = '0;
      element_open_next = 1'b0;
      if (in_beat.elem_type == TYPE_NULL) begin
        clen = '0;
      end
      if (in_beat.elem_type == TYPE_BITSTRING) begin
        extra = 1'b1;
      end else if (in_beat.elem_type == TYPE_INTEGER && clen != 16'd0 &&
                   (in_beat.data_byte & TOP_BIT) != ZERO_BYTE) begin
        extra = 1'b1;
      end
      eff = {1'b0, clen} + {16'd0, extra};

      if (eff > LEN_CAP) begin
        job.bytes  = '0;
        job.cnt    = JOB_CNT_W'(1);
        job.last   = 1'b1;
        job.status = ST_TOO_LONG;
      end else begin
        b[n] = tag_of(in_beat.elem_type);
        n    = n + JOB_CNT_W'(1);
        if (eff < 17'(SHORT_MAX)) begin
          b[n] = eff[7:0];
          n    = n + JOB_CNT_W'(1);
        end else if (eff < 17'd256) begin
          b[n] = LEN_LONG1;
          n    = n + JOB_CNT_W'(1);
          b[n] = eff[7:0];
          n    = n + JOB_CNT_W'(1);
        end else begin
          b[n] = LEN_LONG2;
          n    = n + JOB_CNT_W'(1);
          b[n] = eff[15:8];
          n    = n + JOB_CNT_W'(1);
          b[n] = eff[7:0];
          n    = n + JOB_CNT_W'(1);
        end
        if (extra) begin
          b[n] = ZERO_BYTE;
          n    = n + JOB_CNT_W'(1);
        end
        if (clen != 16'd0) begin
          b[n] = in_beat.data_byte;
          n    = n + JOB_CNT_W'(1);
        end
        if (clen > 16'd1) begin
          bytes_left_next   = clen - 16'd1;
          element_open_next = 1'b1;
        end
        job.bytes  = b;
        job.cnt    = n;
        job.last   = (clen <= 16'd1);
        job.status = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left   <= '0;
      element_open <= 1'b0;
    end else if (push) begin
      bytes_left   <= bytes_left_next;
      element_open <= element_open_next;
    end
  end

endmodule

### sv/dte_queue.sv
module dte_queue import dte_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  job_t    job_in,
  input  logic    pop,
  output job_t    job_out,
  output q_stat_t q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign job_out      = slots[rd_ptr];
  assign q_stat.full  = (count == CW'(DEPTH));
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### sv/dte_back.sv
module dte_back import dte_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  q_stat_t   q_stat,
  input  job_t      q_job,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_beat
);

  logic active;
  job_t cur;
  logic fire, final_beat;

  assign out_valid  = active;
  assign fire       = active && out_ready;
  assign final_beat = (cur.cnt == JOB_CNT_W'(1));
  assign pop        = !q_stat.empty && (!active || (fire && final_beat));

  assign out_beat.out_byte = cur.bytes[0];
  assign out_beat.last     = cur.last && final_beat;
  assign out_beat.status   = cur.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (pop) begin
      active <= 1'b1;
    end else if (fire && final_beat) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_job;
    end else if (fire) begin
      cur.bytes <= {ZERO_BYTE, cur.bytes[JOB_BYTES-1:1]};
      cur.cnt   <= cur.cnt - JOB_CNT_W'(1);
    end
  end

endmodule

### sv/der_tlv_encoder_unit.sv
// DER TLV element encoder.
// Input channel (in_valid/in_ready/in_beat): a start beat names the element
// type, content length and first content byte; a data beat carries the next
// content byte of the open element.
// Output channel (out_valid/out_ready/out_beat): one encoded byte per beat,
// with last on the final byte of the element and a status code; error
// beats carry a zero byte.
// Front end classifies each input beat into a job of one to six bytes and
// pushes it to a small job queue; the back end shifts jobs out a byte a
// cycle from its output register while out_ready is high.
// A job's first byte is offered once the job has passed from its queue
// slot into the back end's output register.
// A data beat becomes one output byte, so content streams at one byte per
// cycle while out_ready is high; a start beat becomes one to six output
// bytes (one for an oversize start, else tag, length in short, 0x81 or 0x82
// form, pad byte, first byte).
// in_ready drops only when the job queue is full, so input keeps flowing
// while the receiver stalls until QUEUE_DEPTH jobs are waiting.
// Reset empties the queue, closes any open element and drops out_valid.
module der_tlv_encoder_unit import dte_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_beat,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_beat
);

  q_stat_t q_stat;
  logic    push, pop;
  job_t    front_job, q_job;

  dte_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_beat  (in_beat),
    .q_stat   (q_stat),
    .push     (push),
    .job      (front_job)
  );

  dte_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .job_in  (front_job),
    .pop     (pop),
    .job_out (q_job),
    .q_stat  (q_stat)
  );

  dte_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .q_job     (q_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !push)
    else $error("push into full job queue");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_stat.empty |-> !pop)
    else $error("pop from empty job queue");

  // Error beats always carry a zero byte
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_beat.status != ST_OK) |-> out_beat.out_byte == ZERO_BYTE)
    else $error("error beat with nonzero byte");

  // Output is quiet straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid high after reset");

endmodule
